[sv/m3inv_pkg.sv]
// ---------------------------------------------------------------------------
// m3inv_pkg: shared constants for the 3x3 matrix inverse
// Register widths, determinant saturation limits and the cofactor
// wiring table (which entries feed each 2x2 cross product).
// ---------------------------------------------------------------------------
package m3inv_pkg;

   localparam int TOL_W   = 63;
   localparam int DET_W   = 64;
   localparam int NUM_ENT = 9;
   localparam int COL_ENT = 3;

   localparam logic [TOL_W-1:0] TOL_RESET = 63'd4295;
   localparam logic [DET_W-1:0] DET_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [DET_W-1:0] DET_MIN   = 64'h8000_0000_0000_0000;

   // cofactor k = p*q - r*s, negated where CROSS_NEG is set (already transposed)
   localparam int CROSS_P [NUM_ENT] = '{4, 1, 1, 3, 0, 0, 3, 0, 0};
   localparam int CROSS_Q [NUM_ENT] = '{8, 8, 5, 8, 8, 5, 7, 7, 4};
   localparam int CROSS_R [NUM_ENT] = '{7, 7, 4, 6, 6, 3, 6, 6, 3};
   localparam int CROSS_S [NUM_ENT] = '{5, 2, 2, 5, 2, 2, 4, 1, 1};
   localparam bit CROSS_NEG [NUM_ENT] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0,
                                          1'b1, 1'b0, 1'b1, 1'b0};

   // column 0 entries used for the determinant expansion
   localparam int COL_IDX [COL_ENT] = '{0, 3, 6};

endpackage

[sv/matrix3x3_inverse.sv]
// ---------------------------------------------------------------------------
// matrix3x3_inverse: pipelined 3x3 fixed-point matrix inverse
// Adjugate over determinant, with singularity check and saturation.
// ---------------------------------------------------------------------------
// Usage:
//   A request (nine signed entries, Q(W/2) fraction bits) is taken at a
//   rising edge with start high and busy low. busy is only high in reset,
//   so one request per cycle is sustained.
//   Each response appears on the rsp_ ports for one cycle with rsp_strobe
//   high. The pipeline holds the restoring divider: an overflow stage,
//   then ENTRY_WIDTH-1 stages, one quotient bit each, shared denominator
//   across all nine entries, after the stages of products, cofactors,
//   determinant and rounding.
//   The receiver cannot stall; results are never held.
//   csr_wr_en writes the singularity tolerance (unsigned Q31.32); write it
//   only when no request is in flight.
//   Reset (synchronous) flushes all in-flight requests and restores the
//   tolerance to its default.
// ---------------------------------------------------------------------------
module matrix3x3_inverse
   import m3inv_pkg::*;
#(
   parameter int ENTRY_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [ENTRY_WIDTH-1:0] req_a00,
   input  logic signed [ENTRY_WIDTH-1:0] req_a01,
   input  logic signed [ENTRY_WIDTH-1:0] req_a02,
   input  logic signed [ENTRY_WIDTH-1:0] req_a10,
   input  logic signed [ENTRY_WIDTH-1:0] req_a11,
   input  logic signed [ENTRY_WIDTH-1:0] req_a12,
   input  logic signed [ENTRY_WIDTH-1:0] req_a20,
   input  logic signed [ENTRY_WIDTH-1:0] req_a21,
   input  logic signed [ENTRY_WIDTH-1:0] req_a22,
   input  logic                          csr_wr_en,
   input  logic [TOL_W-1:0]              csr_wr_data,
   output logic                          rsp_strobe,
   output logic signed [ENTRY_WIDTH-1:0] rsp_inv00,
   output logic signed [ENTRY_WIDTH-1:0] rsp_inv01,
   output logic signed [ENTRY_WIDTH-1:0] rsp_inv02,
   output logic signed [ENTRY_WIDTH-1:0] rsp_inv10,
   output logic signed [ENTRY_WIDTH-1:0] rsp_inv11,
   output logic signed [ENTRY_WIDTH-1:0] rsp_inv12,
   output logic signed [ENTRY_WIDTH-1:0] rsp_inv20,
   output logic signed [ENTRY_WIDTH-1:0] rsp_inv21,
   output logic signed [ENTRY_WIDTH-1:0] rsp_inv22,
   output logic                          rsp_invertible,
   output logic signed [DET_W-1:0]       rsp_det_value
);

   localparam int W    = ENTRY_WIDTH;
   localparam int FRAC = W / 2;
   localparam int PW   = 2 * W;            // 2x2 products
   localparam int CFW  = 2 * W + 1;        // signed cofactor
   localparam int PPW  = 2 * W + 1;        // partial products of det
   localparam int DETW = 3 * W + 2;        // signed determinant
   localparam int MAGW = 3 * W + 1;        // |det|
   localparam int NW   = 3 * W + 2;        // numerator / remainder
   localparam int DENW = MAGW + 1;         // 2*|det|
   localparam int CMPW = 4 * W + 2;        // shifted denominator compare
   localparam int QW   = W - 1;            // quotient bits below saturation
   localparam int TCW  = (MAGW > TOL_W + FRAC) ? MAGW : TOL_W + FRAC;
   localparam int XW   = (MAGW > DET_W + 2) ? MAGW : DET_W + 2;
   localparam int LAT  = W + 8;            // valid stages incl. output register

   // ---------------- control ----------------
   logic             accept;
   logic [LAT-1:0]   vld_ff, vld_in;
   logic [TOL_W-1:0] tol_ff;

   assign busy   = reset;
   assign accept = start & ~busy;
   assign vld_in = {vld_ff[LAT-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         tol_ff <= TOL_RESET;
      end else begin
         vld_ff <= vld_in;
         if (csr_wr_en) begin
            tol_ff <= csr_wr_data;
         end
      end
   end

   // ---------------- S1: 2x2 products ----------------
   logic signed [W-1:0]  a_in [NUM_ENT];
   logic signed [PW-1:0] pq_in [NUM_ENT], pq_ff [NUM_ENT];
   logic signed [PW-1:0] rs_in [NUM_ENT], rs_ff [NUM_ENT];
   logic signed [W-1:0]  col1_ff [COL_ENT];

   assign a_in[0] = req_a00;
   assign a_in[1] = req_a01;
   assign a_in[2] = req_a02;
   assign a_in[3] = req_a10;
   assign a_in[4] = req_a11;
   assign a_in[5] = req_a12;
   assign a_in[6] = req_a20;
   assign a_in[7] = req_a21;
   assign a_in[8] = req_a22;

   always_comb begin
      for (int k = 0; k < NUM_ENT; k++) begin
         pq_in[k] = PW'(a_in[CROSS_P[k]]) * PW'(a_in[CROSS_Q[k]]);
         rs_in[k] = PW'(a_in[CROSS_R[k]]) * PW'(a_in[CROSS_S[k]]);
      end
   end

   always_ff @(posedge clock) begin
      pq_ff <= pq_in;
      rs_ff <= rs_in;
      for (int k = 0; k < COL_ENT; k++) begin
         col1_ff[k] <= a_in[COL_IDX[k]];
      end
   end

   // ---------------- S2: signed cofactors ----------------
   logic signed [CFW-1:0] cof_in [NUM_ENT], cof2_ff [NUM_ENT];
   logic signed [W-1:0]   col2_ff [COL_ENT];

   always_comb begin
      for (int k = 0; k < NUM_ENT; k++) begin
         cof_in[k] = CROSS_NEG[k] ? CFW'(rs_ff[k]) - CFW'(pq_ff[k])
                                  : CFW'(pq_ff[k]) - CFW'(rs_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      cof2_ff <= cof_in;
      col2_ff <= col1_ff;
   end

   // ---------------- S3: det partial products (cofactor split hi/lo) ----------------
   logic signed [PPW-1:0] pph_in [COL_ENT], pph_ff [COL_ENT];
   logic signed [PPW-1:0] ppl_in [COL_ENT], ppl_ff [COL_ENT];
   logic signed [CFW-1:0] cof3_ff [NUM_ENT];

   always_comb begin
      for (int k = 0; k < COL_ENT; k++) begin
         pph_in[k] = PPW'(col2_ff[k]) * PPW'($signed(cof2_ff[k][CFW-1:W]));
         ppl_in[k] = PPW'(col2_ff[k]) * PPW'($signed({1'b0, cof2_ff[k][W-1:0]}));
      end
   end

   always_ff @(posedge clock) begin
      pph_ff  <= pph_in;
      ppl_ff  <= ppl_in;
      cof3_ff <= cof2_ff;
   end

   // ---------------- S4: recombine each term ----------------
   logic signed [DETW-1:0] term_in [COL_ENT], term_ff [COL_ENT];
   logic signed [CFW-1:0]  cof4_ff [NUM_ENT];

   always_comb begin
      for (int k = 0; k < COL_ENT; k++) begin
         term_in[k] = (DETW'(pph_ff[k]) <<< W) + DETW'(ppl_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      term_ff <= term_in;
      cof4_ff <= cof3_ff;
   end

   // ---------------- S5: determinant ----------------
   logic signed [DETW-1:0] det_ff;
   logic signed [CFW-1:0]  cof5_ff [NUM_ENT];

   always_ff @(posedge clock) begin
      det_ff  <= term_ff[0] + term_ff[1] + term_ff[2];
      cof5_ff <= cof4_ff;
   end

   // ---------------- S6: sign / magnitude ----------------
   logic [MAGW-1:0] dmag_in, dmag_ff;
   logic            dneg_ff;
   logic [PW-1:0]   cmag_in [NUM_ENT], cmag_ff [NUM_ENT];
   logic            cneg_ff [NUM_ENT];

   always_comb begin
      dmag_in = det_ff[DETW-1] ? MAGW'(-det_ff) : MAGW'(det_ff);
      for (int k = 0; k < NUM_ENT; k++) begin
         cmag_in[k] = cof5_ff[k][CFW-1] ? PW'(-cof5_ff[k]) : PW'(cof5_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      dmag_ff <= dmag_in;
      dneg_ff <= det_ff[DETW-1];
      cmag_ff <= cmag_in;
      for (int k = 0; k < NUM_ENT; k++) begin
         cneg_ff[k] <= cof5_ff[k][CFW-1];
      end
   end

   // ---------------- S7: divider operands, det rounding, singular check ----------------
   logic [NW-1:0]    num_in [NUM_ENT], num_ff [NUM_ENT];
   logic             sgn7_ff [NUM_ENT];
   logic [DENW-1:0]  den7_ff;
   logic             sing_in, sing7_ff;
   logic [DET_W-1:0] dout_in, dout7_ff;
   logic [XW-1:0]    rnd;
   logic [TCW-1:0]   tol_sh;

   always_comb begin
      for (int k = 0; k < NUM_ENT; k++) begin
         // round(cof * 2^(2F) / d) = floor((2*cof*2^(2F) + d) / (2*d))
         num_in[k] = (NW'(cmag_ff[k]) << (2 * FRAC + 1)) + NW'(dmag_ff);
      end
      tol_sh  = TCW'(tol_ff) << FRAC;
      sing_in = (dmag_ff == '0) || (TCW'(dmag_ff) < tol_sh);
      rnd     = (XW'(dmag_ff) + (XW'(1) << (FRAC - 1))) >> FRAC;
      if (!dneg_ff) begin
         dout_in = (rnd > XW'(DET_MAX)) ? DET_MAX : rnd[DET_W-1:0];
      end else begin
         dout_in = (rnd > XW'(DET_MIN)) ? DET_MIN : -rnd[DET_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      num_ff   <= num_in;
      den7_ff  <= {dmag_ff, 1'b0};
      sing7_ff <= sing_in;
      dout7_ff <= dout_in;
      for (int k = 0; k < NUM_ENT; k++) begin
         sgn7_ff[k] <= cneg_ff[k] ^ dneg_ff;
      end
   end

   // ---------------- divider: overflow stage then one bit per stage ----------------
   logic [NW-1:0]    rem_in [W][NUM_ENT], rem_ff [W][NUM_ENT];
   logic [QW-1:0]    q_in   [W][NUM_ENT], q_ff   [W][NUM_ENT];
   logic             ovf_in [W][NUM_ENT], ovf_ff [W][NUM_ENT];
   logic             sgn_ff [W][NUM_ENT];
   logic [DENW-1:0]  den_ff [W];
   logic             sing_ff [W];
   logic [DET_W-1:0] dout_ff [W];

   always_comb begin
      for (int k = 0; k < NUM_ENT; k++) begin
         rem_in[0][k] = num_ff[k];
         q_in[0][k]   = '0;
         // quotient would reach the saturation limit
         ovf_in[0][k] = CMPW'(num_ff[k]) >= (CMPW'(den7_ff) << (W - 1));
      end
   end

   always_ff @(posedge clock) begin
      rem_ff[0]  <= rem_in[0];
      q_ff[0]    <= q_in[0];
      ovf_ff[0]  <= ovf_in[0];
      sgn_ff[0]  <= sgn7_ff;
      den_ff[0]  <= den7_ff;
      sing_ff[0] <= sing7_ff;
      dout_ff[0] <= dout7_ff;
   end

   for (genvar j = 1; j < W; j++) begin : g_div
      always_comb begin
         logic [CMPW-1:0] sh;
         logic            ge;
         sh = CMPW'(den_ff[j-1]) << (W - 1 - j);
         for (int k = 0; k < NUM_ENT; k++) begin
            ge           = CMPW'(rem_ff[j-1][k]) >= sh;
            rem_in[j][k] = ge ? rem_ff[j-1][k] - NW'(sh) : rem_ff[j-1][k];
            q_in[j][k]   = q_ff[j-1][k] | (ge ? (QW'(1) << (W - 1 - j)) : QW'(0));
            ovf_in[j][k] = ovf_ff[j-1][k];
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[j]  <= rem_in[j];
         q_ff[j]    <= q_in[j];
         ovf_ff[j]  <= ovf_in[j];
         sgn_ff[j]  <= sgn_ff[j-1];
         den_ff[j]  <= den_ff[j-1];
         sing_ff[j] <= sing_ff[j-1];
         dout_ff[j] <= dout_ff[j-1];
      end
   end

   // ---------------- output register: sign, saturate, singular zeroing ----------------
   logic [W-1:0]     inv_in [NUM_ENT], inv_ff [NUM_ENT];
   logic             invertible_ff;
   logic [DET_W-1:0] det_out_ff;

   always_comb begin
      logic [W-1:0] pos_v;
      logic [W-1:0] neg_v;
      for (int k = 0; k < NUM_ENT; k++) begin
         pos_v = ovf_ff[W-1][k] ? {1'b0, {(W-1){1'b1}}} : {1'b0, q_ff[W-1][k]};
         neg_v = ovf_ff[W-1][k] ? {1'b1, {(W-1){1'b0}}} : -{1'b0, q_ff[W-1][k]};
         if (sing_ff[W-1]) begin
            inv_in[k] = '0;
         end else begin
            inv_in[k] = sgn_ff[W-1][k] ? neg_v : pos_v;
         end
      end
   end

   always_ff @(posedge clock) begin
      inv_ff        <= inv_in;
      invertible_ff <= ~sing_ff[W-1];
      det_out_ff    <= dout_ff[W-1];
   end

   assign rsp_strobe     = vld_ff[LAT-1];
   assign rsp_inv00      = $signed(inv_ff[0]);
   assign rsp_inv01      = $signed(inv_ff[1]);
   assign rsp_inv02      = $signed(inv_ff[2]);
   assign rsp_inv10      = $signed(inv_ff[3]);
   assign rsp_inv11      = $signed(inv_ff[4]);
   assign rsp_inv12      = $signed(inv_ff[5]);
   assign rsp_inv20      = $signed(inv_ff[6]);
   assign rsp_inv21      = $signed(inv_ff[7]);
   assign rsp_inv22      = $signed(inv_ff[8]);
   assign rsp_invertible = invertible_ff;
   assign rsp_det_value  = $signed(det_out_ff);

   // ---------------- assertions ----------------
   a_strobe_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe == $past(start && !busy, LAT))
      else $error("response strobe does not match request latency");

   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_invertible |->
         rsp_inv00 == '0 && rsp_inv11 == '0 && rsp_inv22 == '0 &&
         rsp_inv01 == '0 && rsp_inv12 == '0 && rsp_inv20 == '0)
      else $error("singular response carries nonzero inverse entries");

endmodule
